### rtl/assert_macros.svh
// Assertion macros shared by the queue and back-end RTL modules of the jump slot patch encoder.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define JSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define JSP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/jsp_pkg.sv
// Types, instruction templates and word generation for the jump slot patch encoder.
// Used by every module in rtl; depends on nothing.
package jsp_pkg;

  typedef enum logic [2:0] {
    FORM_PTR    = 3'd0,
    FORM_BRANCH = 3'd1,
    FORM_ABS32  = 3'd2,
    FORM_NEG32  = 3'd3,
    FORM_CALL   = 3'd4,
    FORM_ABS42  = 3'd5,
    FORM_NEG41  = 3'd6,
    FORM_FULL64 = 3'd7
  } form_t;

  typedef struct packed {
    logic [63:0] target_addr;
    logic [63:0] slot_addr;
    logic        far_slot;
    logic [63:0] old_pointer;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  word_index;
    logic [63:0] word_value;
    logic [2:0]  form;
    logic        last;
  } out_item_t;

  typedef struct packed {
    form_t       form;
    logic [63:0] val;
  } q_entry_t;

  localparam logic [31:0] I_BAA     = 32'h10400000;
  localparam logic [31:0] I_SETHI   = 32'h03000000;
  localparam logic [31:0] I_JMP     = 32'h81c06000;
  localparam logic [31:0] I_OR      = 32'h82106000;
  localparam logic [31:0] I_ORG5    = 32'h8a116000;
  localparam logic [31:0] I_XOR     = 32'h82186000;
  localparam logic [31:0] I_MOV71   = 32'h8210000f;
  localparam logic [31:0] I_MOV17   = 32'h9e100001;
  localparam logic [31:0] I_CALL    = 32'h40000000;
  localparam logic [31:0] I_SLLX    = 32'h83287000;
  localparam logic [31:0] I_SLLXG5  = 32'h8b297000;
  localparam logic [31:0] I_SRAX    = 32'h83387000;
  localparam logic [31:0] I_SETHIG5 = 32'h0b000000;
  localparam logic [31:0] I_ORG15   = 32'h82804005;

  localparam logic [31:0] SHIFT_10 = 32'd10;
  localparam logic [31:0] SHIFT_22 = 32'd22;
  localparam logic [31:0] SHIFT_32 = 32'd32;

  // Highest word index written for a form; the pointer form writes only word 0.
  function automatic logic [2:0] top_index(form_t f);
    logic [2:0] t;
    unique case (f)
      FORM_PTR:    t = 3'd0;
      FORM_BRANCH: t = 3'd1;
      FORM_ABS32:  t = 3'd2;
      FORM_NEG32:  t = 3'd3;
      FORM_CALL:   t = 3'd3;
      FORM_ABS42:  t = 3'd4;
      FORM_NEG41:  t = 3'd5;
      FORM_FULL64: t = 3'd6;
      default:     t = 3'd0;
    endcase
    return t;
  endfunction

  // The payload v is the new pointer, the branch or call displacement, or the target.
  function automatic logic [63:0] gen_word(form_t f, logic [2:0] idx, logic [63:0] v);
    logic [31:0] w;
    logic [63:0] nv;
    nv = ~v;
    w  = 32'd0;
    unique case (f)
      FORM_PTR:    w = 32'd0;
      FORM_BRANCH: w = I_BAA | {10'd0, v[23:2]};
      FORM_ABS32: begin
        if (idx == 3'd2) w = I_JMP | {22'd0, v[9:0]};
        else             w = I_SETHI | {10'd0, v[31:10]};
      end
      FORM_NEG32: begin
        case (idx)
          3'd3:    w = I_JMP;
          3'd2:    w = I_XOR | {19'd0, nv[12:0]};
          default: w = I_SETHI | {10'd0, nv[31:10]};
        endcase
      end
      FORM_CALL: begin
        case (idx)
          3'd3:    w = I_MOV17;
          3'd2:    w = I_CALL | {2'd0, v[31:2]};
          default: w = I_MOV71;
        endcase
      end
      FORM_ABS42: begin
        case (idx)
          3'd4:    w = I_JMP | {22'd0, v[9:0]};
          3'd3:    w = I_SLLX | SHIFT_10;
          3'd2:    w = I_OR | {22'd0, v[19:10]};
          default: w = I_SETHI | {10'd0, v[41:20]};
        endcase
      end
      FORM_NEG41: begin
        case (idx)
          3'd5:    w = I_JMP | {22'd0, v[9:0]};
          3'd4:    w = I_SRAX | SHIFT_22;
          3'd3:    w = I_SLLX | SHIFT_32;
          3'd2:    w = I_OR | {22'd0, v[19:10]};
          default: w = I_SETHI | {10'd0, v[41:20]};
        endcase
      end
      FORM_FULL64: begin
        case (idx)
          3'd6:    w = I_JMP | {22'd0, v[9:0]};
          3'd5:    w = I_ORG15;
          3'd4:    w = I_SLLXG5 | SHIFT_32;
          3'd3:    w = I_ORG5 | {22'd0, v[41:32]};
          3'd2:    w = I_SETHI | {10'd0, v[31:10]};
          default: w = I_SETHIG5 | {10'd0, v[63:42]};
        endcase
      end
      default: w = 32'd0;
    endcase
    if (f == FORM_PTR) return v;
    return {32'd0, w};
  endfunction

endpackage

### rtl/jsp_front.sv
// Front end: holds the table base register, accepts slots and picks the jump form.
// Depends on jsp_pkg; feeds jsp_queue.
module jsp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [63:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  jsp_pkg::in_item_t  in_item,
  input  logic               q_wr_rdy,
  output logic               q_push,
  output jsp_pkg::q_entry_t  q_wr_data
);

  logic [63:0] base_r;
  logic        s1_vld_r, s1_vld_nxt;
  logic        s1_far_r;
  logic [63:0] s1_target_r, s1_d4_r, s1_d8_r, s1_ptr_r;
  logic        in_acc;
  logic        is_branch, is_call, is_abs32, is_neg32, is_abs42, is_neg41;
  jsp_pkg::form_t form;
  logic [63:0] val;

  assign in_stall = s1_vld_r && !q_wr_rdy;
  assign in_acc   = in_valid && !in_stall;
  assign q_push   = s1_vld_r && q_wr_rdy;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc)      s1_vld_nxt = 1'b1;
    else if (q_push) s1_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= 64'd0;
      s1_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) base_r <= cfg_wr_data;
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_far_r    <= in_item.far_slot;
      s1_target_r <= in_item.target_addr;
      s1_d4_r     <= in_item.target_addr + ~in_item.slot_addr - 64'd3;
      s1_d8_r     <= in_item.target_addr + ~in_item.slot_addr - 64'd7;
      s1_ptr_r    <= in_item.old_pointer + in_item.target_addr - base_r;
    end
  end

  assign is_branch = (s1_d4_r + 64'h0000_0000_0010_0000) <= 64'h0000_0000_0020_0000;
  assign is_call   = (s1_d8_r + 64'h0000_0000_7fff_fffc) <= 64'h0000_0000_ffff_fffc;
  assign is_abs32  = (s1_target_r[63:32] == 32'd0);
  assign is_neg32  = (&s1_target_r[63:32]) && (|s1_target_r[31:0]);
  assign is_abs42  = (s1_target_r[63:42] == 22'd0);
  assign is_neg41  = (&s1_target_r[63:41]) && (|s1_target_r[40:0]);

  always_comb begin
    val = s1_target_r;
    priority if (s1_far_r) begin
      form = jsp_pkg::FORM_PTR;
      val  = s1_ptr_r;
    end else if (is_branch) begin
      form = jsp_pkg::FORM_BRANCH;
      val  = s1_d4_r;
    end else if (is_abs32) begin
      form = jsp_pkg::FORM_ABS32;
    end else if (is_neg32) begin
      form = jsp_pkg::FORM_NEG32;
    end else if (is_call) begin
      form = jsp_pkg::FORM_CALL;
      val  = s1_d8_r;
    end else if (is_abs42) begin
      form = jsp_pkg::FORM_ABS42;
    end else if (is_neg41) begin
      form = jsp_pkg::FORM_NEG41;
    end else begin
      form = jsp_pkg::FORM_FULL64;
    end
  end

  assign q_wr_data.form = form;
  assign q_wr_data.val  = val;

endmodule

### rtl/jsp_queue.sv
// Short queue of classified slots between the front and back ends.
// Depends on jsp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jsp_queue #(
  parameter int QDEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              wr_rdy,
  input  jsp_pkg::q_entry_t wr_data,
  input  logic              pop,
  output logic              rd_vld,
  output jsp_pkg::q_entry_t rd_data
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  jsp_pkg::q_entry_t mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign wr_rdy  = (cnt_r != CW'(QDEPTH));
  assign rd_vld  = (cnt_r != '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  `JSP_NEVER(a_q_overflow, push && !wr_rdy, "Queue written while full.")
  `JSP_NEVER(a_q_underflow, pop && !rd_vld, "Queue read while empty.")

endmodule

### rtl/jsp_back.sv
// Back end: expands the queue head into patch words in the output register, one per cycle unless stalled.
// Depends on jsp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_vld,
  input  jsp_pkg::q_entry_t  q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output jsp_pkg::out_item_t out_item
);

  logic                active_r, active_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic [2:0]          cur_idx;
  logic                cur_last;
  logic                load;
  logic                out_valid_r, out_valid_nxt;
  jsp_pkg::out_item_t  out_item_r;

  assign cur_idx  = active_r ? idx_r : jsp_pkg::top_index(q_head.form);
  assign cur_last = (cur_idx <= 3'd1);
  assign load     = q_vld && (!out_valid_r || !out_stall);
  assign q_pop    = load && cur_last;

  always_comb begin
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      active_nxt    = !cur_last;
      idx_nxt       = cur_idx - 3'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.word_index <= cur_idx;
      out_item_r.word_value <= jsp_pkg::gen_word(q_head.form, cur_idx, q_head.val);
      out_item_r.form       <= q_head.form;
      out_item_r.last       <= cur_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `JSP_ASSERT(a_active_has_head, active_r |-> q_vld, "Slot in progress without a queue entry.")
  `JSP_ASSERT(a_idx_in_range,
    active_r |-> (idx_r != 3'd0 && idx_r < jsp_pkg::top_index(q_head.form)),
    "Word index out of range for the form.")

endmodule

### rtl/jump_slot_patch_encoder_unit.sv
// Top level of the jump slot patch encoder.
// Depends on jsp_pkg, jsp_front, jsp_queue and jsp_back.
//
// Each accepted slot yields one to six patch words, one per cycle while out_stall is low,
// highest word index first, with last set on the final word; far slots and short branches
// give one word, the full 64-bit build gives six. The back end's single output port sets the
// rate: a slot holds it until all of its words are out, while the front end keeps accepting
// slots, one per cycle, until its register and the QDEPTH-entry queue are full. When the
// pipeline is empty, an accepted slot passes through the front-end register and the queue
// before its first word is registered on the output. cfg_wr_data is written to the table base
// register whenever cfg_wr_en is high outside reset; write it only while the block is idle.
module jump_slot_patch_encoder_unit #(
  parameter int QDEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [63:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  jsp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output jsp_pkg::out_item_t out_item
);

  logic              q_push, q_wr_rdy, q_pop, q_vld;
  jsp_pkg::q_entry_t q_wr_data, q_head;

  jsp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .q_wr_rdy    (q_wr_rdy),
    .q_push      (q_push),
    .q_wr_data   (q_wr_data)
  );

  jsp_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_rdy  (q_wr_rdy),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_vld  (q_vld),
    .rd_data (q_head)
  );

  jsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
